// File: hw/rtl/cmcb_pkg.sv
// shared types, register indexes and divide-by-255 helper for the coverage blend unit
// no dependencies
package cmcb_pkg;

    localparam int CHAN_W = 8;
    localparam int PROD_W = 2 * CHAN_W;
    localparam int CFG_IDX_W = 8;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_RED          = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_GREEN        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_BLUE         = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_TRANSPARENCY = 8'd3;

    // reciprocal of 255 scaled by 2^23, exact floor for 16-bit numerators
    localparam logic [16:0] RECIP_255 = 17'h08081;
    localparam int RECIP_SHIFT = 23;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } fill_t;

    // floor(x / 255) for 16-bit x below 255*256, so the result fits 8 bits, one multiply
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W+16:0] prod;
        prod = {17'd0, x} * {{PROD_W{1'b0}}, RECIP_255};
        return prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
    endfunction

endpackage

// File: hw/rtl/cmcb_weight.sv
// weight stages: coverage times opacity, then divide by 255 to get k
// depends on cmcb_pkg
module cmcb_weight
    import cmcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [CHAN_W-1:0] coverage,
    input  pix_t              dest,
    input  logic [CHAN_W-1:0] opacity,
    output logic              dn_valid,
    input  logic              dn_ready,
    output logic [CHAN_W-1:0] k,
    output pix_t              dest_k
);

    logic              s1_valid_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    pix_t              s1_dest_reg;
    logic              s2_valid_reg;
    logic [CHAN_W-1:0] s2_k_reg;
    pix_t              s2_dest_reg;
    logic              s1_ready;
    logic              s2_ready;

    assign s2_ready = !s2_valid_reg || dn_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign up_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && up_valid)
        begin
            s1_prod_reg <= {{CHAN_W{1'b0}}, coverage} * {{CHAN_W{1'b0}}, opacity};
            s1_dest_reg <= dest;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_k_reg    <= div255(s1_prod_reg);
            s2_dest_reg <= s1_dest_reg;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign k        = s2_k_reg;
    assign dest_k   = s2_dest_reg;

endmodule

// File: hw/rtl/cmcb_mix.sv
// mix stages: weighted sums per channel, then divide by 255 into the output register
// depends on cmcb_pkg
module cmcb_mix
    import cmcb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [CHAN_W-1:0] k,
    input  pix_t              dest,
    input  fill_t             fill,
    output logic              dn_valid,
    input  logic              dn_ready,
    output pix_t              result
);

    logic              s3_valid_reg;
    logic [PROD_W-1:0] s3_red_reg;
    logic [PROD_W-1:0] s3_green_reg;
    logic [PROD_W-1:0] s3_blue_reg;
    logic [PROD_W-1:0] s3_alpha_reg;
    logic              s4_valid_reg;
    pix_t              s4_pix_reg;
    logic              s3_ready;
    logic              s4_ready;
    logic [CHAN_W-1:0] ck;

    assign ck = CHAN_MAX - k;

    assign s4_ready = !s4_valid_reg || dn_ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign up_ready = s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= up_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // sums are at most 255*255, so 16 bits hold them
    always_ff @(posedge clk)
    begin
        if (s3_ready && up_valid)
        begin
            s3_red_reg   <= PROD_W'(k) * PROD_W'(fill.red)
                            + PROD_W'(ck) * PROD_W'(dest.red);
            s3_green_reg <= PROD_W'(k) * PROD_W'(fill.green)
                            + PROD_W'(ck) * PROD_W'(dest.green);
            s3_blue_reg  <= PROD_W'(k) * PROD_W'(fill.blue)
                            + PROD_W'(ck) * PROD_W'(dest.blue);
            s3_alpha_reg <= PROD_W'(ck) * PROD_W'(CHAN_MAX - dest.alpha);
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_pix_reg.red   <= div255(s3_red_reg);
            s4_pix_reg.green <= div255(s3_green_reg);
            s4_pix_reg.blue  <= div255(s3_blue_reg);
            s4_pix_reg.alpha <= CHAN_MAX - div255(s3_alpha_reg);
        end
    end

    assign dn_valid = s4_valid_reg;
    assign result   = s4_pix_reg;

endmodule

// File: hw/rtl/coverage_mask_color_blend_unit.sv
// top level of the coverage mask color blend unit: config registers and pipeline
// depends on cmcb_pkg, cmcb_weight, cmcb_mix
//
// channel   direction  handshake               payload
// pix       in         pix_valid / pix_stall   coverage, dest_red/green/blue/alpha
// res       out        res_valid / res_stall   out_red, out_green, out_blue, out_alpha
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// four register stages: a transferred pixel moves through s1, s2, s3 and s4, and its
// result is on the outputs once s4 holds it
// one pixel per clock sustained while res_stall is low; each multiply and each divide
// has its own register stage
// rst_n clears all valid bits and sets the fill registers to zero
// a stalled stage holds its data; earlier stages keep filling bubbles until they meet it
module coverage_mask_color_blend_unit
    import cmcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // pixel input
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  logic [CHAN_W-1:0]    coverage,
    input  logic [CHAN_W-1:0]    dest_red,
    input  logic [CHAN_W-1:0]    dest_green,
    input  logic [CHAN_W-1:0]    dest_blue,
    input  logic [CHAN_W-1:0]    dest_alpha,
    // result output
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [CHAN_W-1:0]    out_red,
    output logic [CHAN_W-1:0]    out_green,
    output logic [CHAN_W-1:0]    out_blue,
    output logic [CHAN_W-1:0]    out_alpha,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAN_W-1:0]    cfg_data
);

    logic [CHAN_W-1:0] fill_red_reg;
    logic [CHAN_W-1:0] fill_green_reg;
    logic [CHAN_W-1:0] fill_blue_reg;
    logic [CHAN_W-1:0] fill_transparency_reg;

    logic              pix_ready;
    pix_t              pix_dest;
    logic              w_valid;
    logic              w_ready;
    logic [CHAN_W-1:0] w_k;
    pix_t              w_dest;
    fill_t             fill;
    pix_t              result;
    logic [CHAN_W-1:0] opacity;

    // config writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_red_reg          <= '0;
            fill_green_reg        <= '0;
            fill_blue_reg         <= '0;
            fill_transparency_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FILL_RED:          fill_red_reg          <= cfg_data;
                CFG_FILL_GREEN:        fill_green_reg        <= cfg_data;
                CFG_FILL_BLUE:         fill_blue_reg         <= cfg_data;
                CFG_FILL_TRANSPARENCY: fill_transparency_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // config must only change while idle (the block does not enforce it), so stages read it directly
    assign opacity    = CHAN_MAX - fill_transparency_reg;
    assign fill.red   = fill_red_reg;
    assign fill.green = fill_green_reg;
    assign fill.blue  = fill_blue_reg;

    assign pix_dest.red   = dest_red;
    assign pix_dest.green = dest_green;
    assign pix_dest.blue  = dest_blue;
    assign pix_dest.alpha = dest_alpha;

    assign pix_stall = !pix_ready;

    // stages 1-2: k = coverage * opacity / 255
    cmcb_weight u_weight (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pix_valid),
        .up_ready (pix_ready),
        .coverage (coverage),
        .dest     (pix_dest),
        .opacity  (opacity),
        .dn_valid (w_valid),
        .dn_ready (w_ready),
        .k        (w_k),
        .dest_k   (w_dest)
    );

    // stages 3-4: blend colors, over-composite alpha, output register
    cmcb_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (w_valid),
        .up_ready (w_ready),
        .k        (w_k),
        .dest     (w_dest),
        .fill     (fill),
        .dn_valid (res_valid),
        .dn_ready (!res_stall),
        .result   (result)
    );

    assign out_red   = result.red;
    assign out_green = result.green;
    assign out_blue  = result.blue;
    assign out_alpha = result.alpha;

endmodule

// File: test/blend_checker.sv
`timescale 1ns / 1ps
// watches the pixel, result and register channels of the coverage blend unit,
// predicts each blended pixel and compares it; depends on cmcb_pkg
module blend_checker
    import cmcb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    input  logic                 pix_stall,
    input  logic [CHAN_W-1:0]    coverage,
    input  logic [CHAN_W-1:0]    dest_red,
    input  logic [CHAN_W-1:0]    dest_green,
    input  logic [CHAN_W-1:0]    dest_blue,
    input  logic [CHAN_W-1:0]    dest_alpha,
    input  logic                 res_valid,
    input  logic                 res_stall,
    input  logic [CHAN_W-1:0]    out_red,
    input  logic [CHAN_W-1:0]    out_green,
    input  logic [CHAN_W-1:0]    out_blue,
    input  logic [CHAN_W-1:0]    out_alpha,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAN_W-1:0]    cfg_data,
    output int                   mismatches,
    output int                   awaiting
);

    fill_t             fill_color;
    logic [CHAN_W-1:0] fill_transp;
    pix_t              blended_q[$];

    // weight = coverage * opacity / 255, then a truncated mix per channel
    function automatic pix_t blend_pixel(input logic [CHAN_W-1:0] cov, input pix_t dst);
        int unsigned weight;
        int unsigned keep;
        pix_t        res;
        weight = (32'(cov) * 32'(CHAN_MAX - fill_transp)) / 255;
        keep = 255 - weight;
        res.red = 8'((weight * fill_color.red + keep * dst.red) / 255);
        res.green = 8'((weight * fill_color.green + keep * dst.green) / 255);
        res.blue = 8'((weight * fill_color.blue + keep * dst.blue) / 255);
        res.alpha = 8'(255 - keep * (255 - 32'(dst.alpha)) / 255);
        return res;
    endfunction

    task automatic check_channel(input string name, input logic [CHAN_W-1:0] want,
                                 input logic [CHAN_W-1:0] got, output bit bad);
        bad = (want !== got);
        if (bad)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pix_t head;
        bit   bad_r, bad_g, bad_b, bad_a;
        if (!rst_n)
        begin
            fill_color = '0;
            fill_transp = '0;
            blended_q.delete();
            mismatches = 0;
            awaiting = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FILL_RED:          fill_color.red = cfg_data;
                    CFG_FILL_GREEN:        fill_color.green = cfg_data;
                    CFG_FILL_BLUE:         fill_color.blue = cfg_data;
                    CFG_FILL_TRANSPARENCY: fill_transp = cfg_data;
                    default: ;
                endcase
            end
            if (pix_valid && !pix_stall)
            begin
                blended_q.push_back(blend_pixel(coverage,
                                                '{dest_red, dest_green, dest_blue, dest_alpha}));
                awaiting++;
            end
            if (res_valid && !res_stall)
            begin
                if (blended_q.size() == 0)
                begin
                    $error("result transfer with no pixel outstanding");
                    mismatches++;
                end
                else
                begin
                    head = blended_q.pop_front();
                    awaiting--;
                    check_channel("out_red", head.red, out_red, bad_r);
                    check_channel("out_green", head.green, out_green, bad_g);
                    check_channel("out_blue", head.blue, out_blue, bad_b);
                    check_channel("out_alpha", head.alpha, out_alpha, bad_a);
                    if (bad_r || bad_g || bad_b || bad_a)
                    begin
                        mismatches++;
                    end
                end
            end
        end
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// top of the coverage blend unit testbench: clock, reset, stimulus and verdict
// depends on cmcb_pkg, coverage_mask_color_blend_unit and blend_checker
module testbench;
    import cmcb_pkg::*;

    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 215;
    localparam int SQUEEZE_LEN  = 60;    // long receiver hold-off, fills the pipeline
    localparam int QUIET_LIMIT  = 1000;  // cycles with no transfer before giving up
    localparam int TAIL_CYCLES  = 12;    // margin beyond the four pipeline stages

    logic                 clk;
    logic                 rst_n;
    logic                 pix_valid;
    logic                 pix_stall;
    logic [CHAN_W-1:0]    coverage;
    logic [CHAN_W-1:0]    dest_red;
    logic [CHAN_W-1:0]    dest_green;
    logic [CHAN_W-1:0]    dest_blue;
    logic [CHAN_W-1:0]    dest_alpha;
    logic                 res_valid;
    logic                 res_stall;
    logic [CHAN_W-1:0]    out_red;
    logic [CHAN_W-1:0]    out_green;
    logic [CHAN_W-1:0]    out_blue;
    logic [CHAN_W-1:0]    out_alpha;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CHAN_W-1:0]    cfg_data;

    int mismatches;
    int awaiting;

    // per-phase idling knobs, percent chance of starting a burst
    int gap_pct;
    int stall_pct;
    bit squeeze_go;
    bit squeeze_done;

    coverage_mask_color_blend_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .coverage   (coverage),
        .dest_red   (dest_red),
        .dest_green (dest_green),
        .dest_blue  (dest_blue),
        .dest_alpha (dest_alpha),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    blend_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .coverage   (coverage),
        .dest_red   (dest_red),
        .dest_green (dest_green),
        .dest_blue  (dest_blue),
        .dest_alpha (dest_alpha),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // mostly uniform bytes, with the channel extremes showing up often
    function automatic logic [CHAN_W-1:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
        begin
            return '0;
        end
        if (roll == 1)
        begin
            return CHAN_MAX;
        end
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    // one pixel transfer; optionally a sender gap first, then hold until accepted
    task automatic send_pixel(input logic [CHAN_W-1:0] cov, input pix_t dst);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        coverage <= cov;
        dest_red <= dst.red;
        dest_green <= dst.green;
        dest_blue <= dst.blue;
        dest_alpha <= dst.alpha;
        pix_valid <= 1'b1;
        @(posedge clk);
        while (pix_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // valid stays up across back-to-back writes; caller drops it afterwards
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CHAN_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // all four fill registers plus one write to an index that does not exist
    task automatic set_fill(input fill_t color, input logic [CHAN_W-1:0] transp,
                            input logic [CFG_IDX_W-1:0] junk_idx);
        write_reg(CFG_FILL_RED, color.red);
        write_reg(CFG_FILL_GREEN, color.green);
        write_reg(CFG_FILL_BLUE, color.blue);
        write_reg(CFG_FILL_TRANSPARENCY, transp);
        write_reg(junk_idx, CHAN_W'($urandom_range(0, 255)));
        cfg_valid <= 1'b0;
    endtask

    // drop valid and let every outstanding pixel come back before touching registers
    task automatic drain();
        pix_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (awaiting != 0);
    endtask

    function automatic logic [CFG_IDX_W-1:0] bad_index();
        return CFG_IDX_W'($urandom_range(int'(CFG_FILL_TRANSPARENCY) + 1, 255));
    endfunction

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin : receiver
        res_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (squeeze_go && !squeeze_done)
            begin
                res_stall <= 1'b1;
                repeat (SQUEEZE_LEN) @(negedge clk);
                res_stall <= 1'b0;
                squeeze_done = 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    // ends the run when no channel has moved for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall)
                || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        fill_t       color;
        logic [7:0]  transp;
        rst_n = 1'b0;
        pix_valid = 1'b0;
        coverage = '0;
        dest_red = '0;
        dest_green = '0;
        dest_blue = '0;
        dest_alpha = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        gap_pct = 0;
        stall_pct = 0;
        squeeze_go = 1'b0;
        squeeze_done = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers at reset: black fill, fully opaque
        send_pixel(8'd0, '{8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(8'd255, '{8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel(8'd255, '{8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(8'd0, '{8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel(8'd128, '{8'd200, 8'd100, 8'd50, 8'd0});
        drain();

        // white opaque fill; the all-ones index must be ignored
        set_fill('{8'd255, 8'd255, 8'd255}, 8'd0, {CFG_IDX_W{1'b1}});
        send_pixel(8'd255, '{8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(8'd1, '{8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(8'd254, '{8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(8'd0, '{8'd17, 8'd34, 8'd51, 8'd68});
        send_pixel(8'd255, '{8'd255, 8'd255, 8'd255, 8'd0});
        send_pixel(8'd128, '{8'd0, 8'd255, 8'd0, 8'd255});
        send_pixel(8'd85, '{8'd170, 8'd85, 8'd170, 8'd85});
        send_pixel(8'd170, '{8'd1, 8'd254, 8'd127, 8'd128});
        send_pixel(8'd255, '{8'd255, 8'd255, 8'd255, 8'd255});
        send_pixel(8'd3, '{8'd255, 8'd0, 8'd255, 8'd0});

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            color = '{CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                      CHAN_W'($urandom_range(0, 255))};
            transp = CHAN_W'($urandom_range(0, 255));
            case (p)
                0: transp = CHAN_MAX;  // fully transparent fill, pixels pass through
                2:
                begin
                    color = '0;
                    transp = '0;
                end
                4:
                begin
                    color = '{CHAN_MAX, 8'd0, CHAN_MAX};
                    transp = 8'd254;
                end
                default: ;
            endcase
            set_fill(color, transp, bad_index());

            // the long hold-off goes with a sender that never idles
            gap_pct = (p == 2) ? 0 : $urandom_range(0, 40);
            stall_pct = $urandom_range(0, 40);
            if (p == 2)
            begin
                squeeze_go = 1'b1;
            end
            // last phase runs flat out on both sides
            if (p == PHASES - 1)
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_pixel(pick_byte(), '{pick_byte(), pick_byte(), pick_byte(), pick_byte()});
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaiting != 0)
        begin
            $error("%0d blended pixels never came back", awaiting);
        end
        if (mismatches == 0 && awaiting == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: coverage_mask_color_blend_unit.f
hw/rtl/cmcb_pkg.sv
hw/rtl/cmcb_weight.sv
hw/rtl/cmcb_mix.sv
hw/rtl/coverage_mask_color_blend_unit.sv
test/blend_checker.sv
test/testbench.sv
